@@ design/pcs_pkg.sv @@
// shared types and constants for the python comment stripper
// no dependencies; used by pcs_step and python_comment_stripper
package pcs_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  localparam logic [1:0] RUN_FULL  = 2'd3;
  localparam logic [1:0] BLANK_MAX = 2'd2;

  localparam logic [1:0] DOC_NONE   = 2'd0;
  localparam logic [1:0] DOC_SINGLE = 2'd1;
  localparam logic [1:0] DOC_DOUBLE = 2'd2;

  typedef struct packed {
    logic [1:0] doc_mode;
    logic       single_open;
    logic [1:0] single_run;
    logic       double_open;
    logic [1:0] double_run;
    logic [7:0] prev_char;
    logic [7:0] last_kept;
    logic [1:0] blank_run;
    logic       escape_pending;
    logic       in_comment;
  } pcs_state_t;

  localparam pcs_state_t STATE_RST = '{
    doc_mode:       DOC_NONE,
    single_open:    1'b0,
    single_run:     2'd0,
    double_open:    1'b0,
    double_run:     2'd0,
    prev_char:      8'h00,
    last_kept:      CH_SPACE,
    blank_run:      2'd0,
    escape_pending: 1'b0,
    in_comment:     1'b0
  };

endpackage

@@ design/pcs_step.sv @@
// next-state and keep/drop decision for one source byte
// depends on pcs_pkg
module pcs_step (
  input  pcs_pkg::pcs_state_t state_i,
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output pcs_pkg::pcs_state_t state_o,
  output logic                emit_o,
  output logic [7:0]          char_o
);
  import pcs_pkg::*;

  typedef struct packed {
    logic [1:0] doc_mode;
    logic [1:0] run;
    logic       open;
    logic       other_open;
    logic       skip;
  } quote_res_t;

  // quote handling for one quote kind
  function automatic quote_res_t quote_upd(
    input logic [1:0] doc_mode,
    input logic [1:0] run,
    input logic       open,
    input logic       other_open,
    input logic       prev_is_q,
    input logic       esc,
    input logic [1:0] kind
  );
    quote_res_t r;
    r.doc_mode   = doc_mode;
    r.run        = run;
    r.open       = open;
    r.other_open = other_open;
    r.skip       = 1'b0;
    if (doc_mode != DOC_NONE) begin
      if (run == RUN_FULL || prev_is_q) begin
        if (run != 2'd0) r.run = run - 2'd1;
      end else begin
        r.run = RUN_FULL;
      end
      r.doc_mode = (r.run != 2'd0) ? kind : DOC_NONE;
      r.skip     = (r.doc_mode == DOC_NONE);
    end else begin
      if ((run == 2'd0 && !(open || other_open)) || prev_is_q) begin
        if (run != RUN_FULL) r.run = run + 2'd1;
      end
      r.doc_mode = (r.run == RUN_FULL) ? kind : DOC_NONE;
      if (r.doc_mode != DOC_NONE) begin
        r.open       = 1'b0;
        r.other_open = 1'b0;
        r.skip       = 1'b1;
      end else if (!other_open) begin
        if (open) begin
          if (!esc) begin
            r.open = 1'b0;
            r.skip = 1'b1;
          end
        end else begin
          r.open = 1'b1;
        end
      end
    end
    return r;
  endfunction

  always_comb begin
    pcs_state_t n;
    quote_res_t qr;
    logic       skip;
    logic       kept;
    logic       any_q;
    n    = state_i;
    qr   = '0;
    skip = 1'b0;
    kept = 1'b0;
    any_q = state_i.single_open || state_i.double_open || state_i.doc_mode != DOC_NONE;

    if (!state_i.in_comment && !any_q && !state_i.escape_pending && char_i == CH_HASH) begin
      n.in_comment = 1'b1;
      n.blank_run  = 2'd0;
    end else if (state_i.in_comment && char_i != CH_NL) begin
      // comment byte, dropped
    end else begin
      if (char_i == CH_NL) begin
        skip         = (state_i.last_kept == CH_NL);
        n.in_comment = 1'b0;
        n.blank_run  = 2'd0;
      end else if (char_i == CH_DQ) begin
        if (state_i.doc_mode != DOC_SINGLE) begin
          qr = quote_upd(state_i.doc_mode, state_i.double_run, state_i.double_open,
                         state_i.single_open, state_i.prev_char == CH_DQ,
                         state_i.escape_pending, DOC_DOUBLE);
          n.doc_mode    = qr.doc_mode;
          n.double_run  = qr.run;
          n.double_open = qr.open;
          n.single_open = qr.other_open;
          skip          = qr.skip;
        end
        n.blank_run = 2'd0;
      end else if (char_i == CH_SQ) begin
        if (state_i.doc_mode != DOC_DOUBLE) begin
          qr = quote_upd(state_i.doc_mode, state_i.single_run, state_i.single_open,
                         state_i.double_open, state_i.prev_char == CH_SQ,
                         state_i.escape_pending, DOC_SINGLE);
          n.doc_mode    = qr.doc_mode;
          n.single_run  = qr.run;
          n.single_open = qr.open;
          n.double_open = qr.other_open;
          skip          = qr.skip;
        end
        n.blank_run = 2'd0;
      end else if (char_i == CH_TAB || char_i == CH_SPACE) begin
        if (state_i.last_kept == CH_NL) skip = 1'b1;
        else if (state_i.blank_run < BLANK_MAX) n.blank_run = state_i.blank_run + 2'd1;
      end else begin
        n.blank_run = 2'd0;
      end

      // run counters follow the docstring mode left by this byte
      if (n.doc_mode == DOC_SINGLE) begin
        if (n.single_run < RUN_FULL && char_i != CH_SQ) n.single_run = RUN_FULL;
        n.double_run = 2'd0;
      end else if (n.doc_mode == DOC_DOUBLE) begin
        if (n.double_run < RUN_FULL && char_i != CH_DQ) n.double_run = RUN_FULL;
        n.single_run = 2'd0;
      end else begin
        if (char_i != CH_SQ) n.single_run = 2'd0;
        if (char_i != CH_DQ) n.double_run = 2'd0;
      end

      if (!skip && !(n.single_open || n.double_open || n.doc_mode != DOC_NONE)
          && n.blank_run < BLANK_MAX) begin
        kept        = 1'b1;
        n.last_kept = char_i;
      end
      n.escape_pending = (char_i == CH_BSL) ? !state_i.escape_pending : 1'b0;
    end
    n.prev_char = char_i;

    emit_o  = kept;
    char_o  = kept ? char_i : 8'h00;
    state_o = last_i ? STATE_RST : n;
  end

endmodule

@@ design/python_comment_stripper.sv @@
// python comment stripper: one source byte in, one keep/drop result out
// result path: the input register, then the result register
// throughput: one byte per cycle while not stalled; the state update is a single pass of pcs_step
// stalls only when both the input and result registers are full and the result is not taken downstream
// reset: async active low, clears the stripper state and both valid flags
// the stripper state also returns to its reset value after an item with tlast set
module python_comment_stripper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_char
  output logic        m_axis_tuser,   // [0] emit
  output logic        m_axis_tlast    // out_last
);
  import pcs_pkg::*;

  logic       in_v_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       out_v_q;
  logic       emit_q;
  logic [7:0] out_char_q;
  logic       out_last_q;
  pcs_state_t state_q, state_d;
  logic       step_emit;
  logic [7:0] step_char;
  logic       advance;

  // compute stage moves forward when the result register is free or being drained
  assign advance       = !out_v_q || m_axis_tready;
  assign s_axis_tready = !in_v_q || advance;

  pcs_step u_step (
    .state_i (state_q),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .emit_o  (step_emit),
    .char_o  (step_char)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= STATE_RST;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      if (advance) out_v_q <= in_v_q;
      if (advance && in_v_q) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_v_q) begin
      emit_q     <= step_emit;
      out_char_q <= step_char;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = emit_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'h00))
    else $error("dropped item carries nonzero char");

  a_doc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.doc_mode != 2'd3)
    else $error("invalid docstring mode");

  a_one_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.single_open && state_q.double_open))
    else $error("both plain strings open");

  a_last_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_v_q && in_last_q) |=> (state_q == STATE_RST))
    else $error("state not cleared after last item");
`endif

endmodule
